FILE: src/tbe_pkg.sv
// ----------------------------------------------------------------------------
// Bandwidth estimator package
// Field widths, fixed-point constants and shared types of the estimator.
// ----------------------------------------------------------------------------
package tbe_pkg;

	localparam int LEN_W     = 16;
	localparam int TS_W      = 32;
	localparam int RATE_W    = 32;
	localparam int EST_W     = 33;
	localparam int TAU_W     = 24;
	localparam int FRAC_W    = 16;

	// Quotient width of the shared divider and its step counter
	localparam int QUO_W     = 33;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	// Split of the 33-bit multiplicand into two partial products
	localparam int LO_W      = 17;
	localparam int HI_W      = EST_W - LO_W;

	localparam logic [TAU_W-1:0] TAU_RESET = TAU_W'(100000);
	localparam logic [EST_W-1:0] EST_MAX   = 33'h0_FFFF_FFFF;
	localparam logic [EST_W-1:0] EST_MIN   = 33'h1_0000_0000;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: src/tbe_pkt_if.sv
// ----------------------------------------------------------------------------
// Packet channel
// Valid/ready channel carrying one packet arrival or timer tick.
// ----------------------------------------------------------------------------
interface tbe_pkt_if import tbe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] pkt_length;
	logic [TS_W-1:0]  timestamp_us;

	modport source (output valid, output pkt_length, output timestamp_us, input ready);
	modport sink (input valid, input pkt_length, input timestamp_us, output ready);
endinterface

FILE: src/tbe_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the rate and the filtered estimate.
// ----------------------------------------------------------------------------
interface tbe_res_if import tbe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [RATE_W-1:0]        inst_rate;
	logic signed [EST_W-1:0]  bandwidth;
	logic                     delta_clamped;

	modport source (output valid, output inst_rate, output bandwidth,
		output delta_clamped, input ready);
	modport sink (input valid, input inst_rate, input bandwidth,
		input delta_clamped, output ready);
endinterface

FILE: src/tbe_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the filter time constant.
// ----------------------------------------------------------------------------
interface tbe_cfg_if import tbe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TAU_W-1:0] tau_us;

	modport source (output valid, output tau_us, input ready);
	modport sink (input valid, input tau_us, output ready);
endinterface

FILE: src/tbe_front.sv
// ----------------------------------------------------------------------------
// Bandwidth estimator front end
// Accepts items, measures the wrapped time step and clamps it.
// ----------------------------------------------------------------------------
module tbe_front import tbe_pkg::*; #(
	parameter int MAX_DELTA_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tbe_pkt_if.sink                              pkt_in,
	input  logic                                 q_full,
	output logic                                 q_push,
	output logic [1+LEN_W+MAX_DELTA_BITS+1-1:0]  q_data
);

	localparam int DLT_W = MAX_DELTA_BITS + 1;
	localparam logic [TS_W-1:0] LIMIT = TS_W'(1) << MAX_DELTA_BITS;

	logic [TS_W-1:0]  last_time_q;
	logic [TS_W-1:0]  raw_delta;
	logic [DLT_W-1:0] delta;
	logic             clamped;

	assign pkt_in.ready = !q_full;
	assign q_push       = pkt_in.valid && !q_full;
	assign raw_delta    = pkt_in.timestamp_us - last_time_q;

	always_comb begin
		if (raw_delta == '0) begin
			delta   = DLT_W'(1);
			clamped = 1'b1;
		end else if (raw_delta > LIMIT) begin
			delta   = LIMIT[DLT_W-1:0];
			clamped = 1'b1;
		end else begin
			delta   = raw_delta[DLT_W-1:0];
			clamped = 1'b0;
		end
	end

	assign q_data = {clamped, pkt_in.pkt_length, delta};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
		end else if (q_push) begin
			last_time_q <= pkt_in.timestamp_us;
		end
	end

endmodule

FILE: src/tbe_queue.sv
// ----------------------------------------------------------------------------
// Bandwidth estimator queue
// Two-entry queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module tbe_queue import tbe_pkg::*; #(
	parameter int WIDTH = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: src/tbe_div.sv
// ----------------------------------------------------------------------------
// Bandwidth estimator divider
// Radix-2 restoring divider producing a 33-bit quotient, one bit a cycle.
// ----------------------------------------------------------------------------
module tbe_div import tbe_pkg::*; #(
	parameter int DEN_W = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] divisor,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [QUO_W-1:0] dividend,
	output div_stat_t        stat,
	output logic [QUO_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     dsr_q;
	logic [QUO_W-1:0]     dvd_q;
	logic [DEN_W:0]       part;
	logic [DEN_W:0]       diff;
	logic                 ge;

	assign part = {rem_q, dvd_q[QUO_W-1]};
	assign ge   = (part >= {1'b0, dsr_q});
	assign diff = part - {1'b0, dsr_q};

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: src/tbe_back.sv
// ----------------------------------------------------------------------------
// Bandwidth estimator back end
// Sequences the rate division, the filter products and the estimate division.
// ----------------------------------------------------------------------------
module tbe_back import tbe_pkg::*; #(
	parameter int MAX_DELTA_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tbe_cfg_if.sink                              cfg_wr,
	input  logic                                 q_valid,
	input  logic [1+LEN_W+MAX_DELTA_BITS+1-1:0]  q_data,
	output logic                                 q_pop,
	tbe_res_if.source                            res_out
);

	localparam int DLT_W = MAX_DELTA_BITS + 1;
	localparam int TT_W  = TAU_W + 1;
	localparam int AW    = (TT_W > DLT_W) ? TT_W : DLT_W;
	localparam int DEN_W = AW + 1;
	localparam int PP_W  = AW + LO_W;
	localparam int ACC_W = AW + EST_W + 2;
	localparam int MAG_W = ACC_W - 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_T1    = 3'd1;
	localparam logic [2:0] S_RATE  = 3'd2;
	localparam logic [2:0] S_T2    = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_ESTS  = 3'd5;
	localparam logic [2:0] S_EST   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0]             state_q;
	logic                   half_q;
	logic [TAU_W-1:0]       tau_q;
	logic [RATE_W-1:0]      prev_rate_q;
	logic [EST_W-1:0]       prev_est_q;
	logic [DLT_W-1:0]       delta_q;
	logic                   clamped_q;
	logic [AW-1:0]          a_mag_q;
	logic [EST_W-1:0]       b_mag_q;
	logic                   neg_q;
	logic [PP_W-1:0]        pp_s1;
	logic                   pp_vld_s1;
	logic                   pp_neg_s1;
	logic                   pp_hi_s1;
	logic [ACC_W-1:0]       acc_q;
	logic                   est_neg_q;
	logic                   est_sat_q;
	logic                   res_valid_q;
	logic [RATE_W-1:0]      res_rate_q;
	logic [EST_W-1:0]       res_bw_q;
	logic                   res_clamp_q;

	logic [DLT_W-1:0]       e_delta;
	logic [LEN_W-1:0]       e_len;
	logic                   e_clamped;
	logic [TT_W-1:0]        two_tau;
	logic [DEN_W-1:0]       den;
	logic [DEN_W-1:0]       diff1;
	logic [AW-1:0]          diff1_mag;
	logic                   est_sign;
	logic [EST_W-1:0]       est_mag;
	logic                   issue;
	logic [LO_W-1:0]        b_half;
	logic [ACC_W-1:0]       pp_ext;
	logic [ACC_W-1:0]       acc_abs;
	logic [MAG_W-1:0]       num_mag;
	logic [DEN_W-1:0]       num_hi;
	logic                   div_start;
	logic [DEN_W-1:0]       div_dsr;
	logic [DEN_W-1:0]       div_rem;
	logic [QUO_W-1:0]       div_dvd;
	div_stat_t              div_stat;
	logic [QUO_W-1:0]       div_quo;
	logic [EST_W-1:0]       est_val;
	logic                   res_load;

	assign {e_clamped, e_len, e_delta} = q_data;

	assign cfg_wr.ready = 1'b1;

	assign two_tau   = {tau_q, 1'b0};
	assign den       = DEN_W'(two_tau) + DEN_W'(delta_q);
	assign diff1     = DEN_W'(two_tau) - DEN_W'(e_delta);
	assign diff1_mag = diff1[DEN_W-1] ? AW'(DEN_W'(0) - diff1) : diff1[AW-1:0];
	assign est_sign  = prev_est_q[EST_W-1];
	assign est_mag   = est_sign ? (EST_W'(0) - prev_est_q) : prev_est_q;

	assign q_pop = (state_q == S_IDLE) && q_valid;

	// Multiplier: one partial product a cycle, registered before accumulation
	assign issue  = (state_q == S_T1) || (state_q == S_T2);
	assign b_half = half_q ? LO_W'(b_mag_q[EST_W-1:LO_W]) : b_mag_q[LO_W-1:0];
	assign pp_ext = pp_hi_s1 ? (ACC_W'(pp_s1) << LO_W) : ACC_W'(pp_s1);

	assign acc_abs = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
	assign num_mag = acc_abs[MAG_W-1:0];
	assign num_hi  = num_mag[MAG_W-1:QUO_W];

	always_comb begin
		div_start = 1'b0;
		div_dsr   = DEN_W'(e_delta);
		div_rem   = '0;
		div_dvd   = {1'b0, e_len, FRAC_W'(0)};
		case (state_q)
			S_IDLE: begin
				div_start = q_valid;
			end
			S_ESTS: begin
				div_start = 1'b1;
				div_dsr   = den;
				div_rem   = num_hi;
				div_dvd   = num_mag[QUO_W-1:0];
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	tbe_div #(
		.DEN_W(DEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (div_dsr),
		.rem_init(div_rem),
		.dividend(div_dvd),
		.stat    (div_stat),
		.quotient(div_quo)
	);

	always_comb begin
		if (est_sat_q) begin
			est_val = est_neg_q ? EST_MIN : EST_MAX;
		end else if (!est_neg_q) begin
			est_val = div_quo[QUO_W-1] ? EST_MAX : div_quo;
		end else begin
			est_val = (div_quo > EST_MIN) ? EST_MIN : (EST_W'(0) - div_quo);
		end
	end

	assign res_load = (state_q == S_OUT) && (!res_valid_q || res_out.ready);

	assign res_out.valid         = res_valid_q;
	assign res_out.inst_rate     = res_rate_q;
	assign res_out.bandwidth     = res_bw_q;
	assign res_out.delta_clamped = res_clamp_q;

	always_ff @(posedge clk) begin
		pp_s1     <= a_mag_q * b_half;
		pp_neg_s1 <= neg_q;
		pp_hi_s1  <= half_q;
		if (q_pop) begin
			delta_q   <= e_delta;
			clamped_q <= e_clamped;
			a_mag_q   <= diff1_mag;
			b_mag_q   <= est_mag;
			neg_q     <= diff1[DEN_W-1] ^ est_sign;
		end else if ((state_q == S_RATE) && div_stat.done) begin
			a_mag_q <= AW'(delta_q);
			b_mag_q <= EST_W'(div_quo[RATE_W-1:0]) + EST_W'(prev_rate_q);
			neg_q   <= 1'b0;
		end
		if (q_pop) begin
			acc_q <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= pp_neg_s1 ? (acc_q - pp_ext) : (acc_q + pp_ext);
		end
		if (state_q == S_ESTS) begin
			est_neg_q <= acc_q[ACC_W-1];
			est_sat_q <= (num_hi >= den);
		end
		if (res_load) begin
			res_rate_q  <= prev_rate_q;
			res_bw_q    <= prev_est_q;
			res_clamp_q <= clamped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			half_q      <= 1'b0;
			pp_vld_s1   <= 1'b0;
			tau_q       <= TAU_RESET;
			prev_rate_q <= '0;
			prev_est_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			pp_vld_s1 <= issue;
			if (cfg_wr.valid) begin
				tau_q <= cfg_wr.tau_us;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					half_q <= 1'b0;
					if (q_valid) begin
						state_q <= S_T1;
					end
				end
				S_T1: begin
					half_q <= !half_q;
					if (half_q) begin
						state_q <= S_RATE;
					end
				end
				S_RATE: begin
					if (div_stat.done) begin
						prev_rate_q <= div_quo[RATE_W-1:0];
						state_q     <= S_T2;
					end
				end
				S_T2: begin
					half_q <= !half_q;
					if (half_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_ESTS;
				end
				S_ESTS: begin
					state_q <= S_EST;
				end
				S_EST: begin
					if (div_stat.done) begin
						prev_est_q <= est_val;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/tustin_bandwidth_estimator.sv
// ----------------------------------------------------------------------------
// Tustin bandwidth estimator
// Bilinear low-pass filter over instantaneous byte rates of a packet stream.
// ----------------------------------------------------------------------------
// Each packet or timer tick yields one result: instantaneous rate in Q16.16
// and filtered estimate in signed Q17.16, both in bytes per microsecond. The
// front end takes an item whenever its two-entry queue has room; the back
// end takes the next item once the last result is loaded, paced by the shared
// radix-2 divider, 33 steps for the rate and 33 for the estimate. The time
// constant may only be written while no transfer is outstanding.
module tustin_bandwidth_estimator import tbe_pkg::*; #(
	parameter int MAX_DELTA_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	tbe_pkt_if.sink    pkt_in,
	tbe_cfg_if.sink    cfg_wr,
	tbe_res_if.source  res_out
);

	localparam int ENTRY_W = 1 + LEN_W + MAX_DELTA_BITS + 1;

	logic               q_full;
	logic               q_push;
	logic [ENTRY_W-1:0] q_wdata;
	logic               q_pop;
	logic               q_valid;
	logic [ENTRY_W-1:0] q_rdata;

	tbe_front #(
		.MAX_DELTA_BITS(MAX_DELTA_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.pkt_in(pkt_in),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	tbe_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_data (q_rdata)
	);

	tbe_back #(
		.MAX_DELTA_BITS(MAX_DELTA_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.q_valid(q_valid),
		.q_data (q_rdata),
		.q_pop  (q_pop),
		.res_out(res_out)
	);

endmodule

FILE: dv/tb_tustin_bandwidth_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bandwidth estimator testbench
// Drives packet arrivals and timer ticks through the estimator under several
// filter time constants. A scoreboard predicts the rate, the filtered estimate
// and the clamp flag of every result, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_tustin_bandwidth_estimator;
	import tbe_pkg::*;

	localparam int MAX_DELTA_BITS = 24;
	localparam int STALL_LIMIT    = 4000;
	localparam int DRAIN_CYCLES   = 200;

	typedef struct {
		logic [RATE_W-1:0]       rate;
		logic signed [EST_W-1:0] bw;
		logic                    clamped;
	} bw_result_t;

	class bw_scoreboard;
		logic [TAU_W-1:0]  tau;
		logic [TS_W-1:0]   last_time;
		logic [RATE_W-1:0] prev_rate;
		longint            prev_est;
		bw_result_t        awaited[$];
		int                errors;
		int                n_items;
		int                n_clamped;
		int                n_saturated;

		function new();
			tau         = TAU_RESET;
			last_time   = '0;
			prev_rate   = '0;
			prev_est    = 0;
			errors      = 0;
			n_items     = 0;
			n_clamped   = 0;
			n_saturated = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_input(logic [LEN_W-1:0] len, logic [TS_W-1:0] ts);
			logic [TS_W-1:0]      delta;
			logic [TS_W-1:0]      limit;
			logic                 clamp;
			longint unsigned      scaled;
			logic [RATE_W-1:0]    rate;
			longint               two_tau;
			longint               num;
			longint               den;
			longint               est;
			bw_result_t           r;
			limit = TS_W'(1) << MAX_DELTA_BITS;
			delta = ts - last_time;
			clamp = 1'b0;
			if (delta == 0) begin
				delta = 1;
				clamp = 1'b1;
			end else if (delta > limit) begin
				delta = limit;
				clamp = 1'b1;
			end
			scaled  = {32'h0, len, 16'h0};
			rate    = RATE_W'(scaled / longint'({32'h0, delta}));
			two_tau = 2 * longint'({40'h0, tau});
			num = (two_tau - longint'({32'h0, delta})) * prev_est
				+ longint'({32'h0, delta})
				* (longint'({32'h0, rate}) + longint'({32'h0, prev_rate}));
			den = two_tau + longint'({32'h0, delta});
			est = num / den;
			if (est > 64'sh0_FFFF_FFFF) begin
				est = 64'sh0_FFFF_FFFF;
				n_saturated++;
			end
			if (est < -64'sh1_0000_0000) begin
				est = -64'sh1_0000_0000;
				n_saturated++;
			end
			prev_est  = est;
			prev_rate = rate;
			last_time = ts;
			r.rate    = rate;
			r.bw      = est[EST_W-1:0];
			r.clamped = clamp;
			awaited.push_back(r);
			n_items++;
			if (clamp)
				n_clamped++;
		endfunction

		function void check_result(logic [RATE_W-1:0] rate, logic signed [EST_W-1:0] bw,
				logic clamped);
			bw_result_t e;
			if (awaited.size() == 0) begin
				$error("result with no input outstanding: inst_rate %h bandwidth %h", rate, bw);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (rate !== e.rate) begin
				$error("inst_rate: expected %h, actual %h", e.rate, rate);
				errors++;
			end
			if (bw !== e.bw) begin
				$error("bandwidth: expected %0d, actual %0d", e.bw, bw);
				errors++;
			end
			if (clamped !== e.clamped) begin
				$error("delta_clamped: expected %b, actual %b", e.clamped, clamped);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   quiet_cycles;
	logic [TS_W-1:0] cur_ts;

	tbe_pkt_if pkt_ch();
	tbe_cfg_if cfg_ch();
	tbe_res_if res_ch();

	bw_scoreboard gold = new();

	tustin_bandwidth_estimator #(.MAX_DELTA_BITS(MAX_DELTA_BITS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt_in (pkt_ch),
		.cfg_wr (cfg_ch),
		.res_out(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				gold.check_result(res_ch.inst_rate, res_ch.bandwidth, res_ch.delta_clamped);
			res_ch.ready <= (arst_n && $urandom_range(99) >= idle_pct);
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					STALL_LIMIT, gold.pending());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_pkt(input logic [LEN_W-1:0] len, input logic [TS_W-1:0] ts);
		while ($urandom_range(99) < idle_pct) begin
			pkt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pkt_ch.valid        <= 1'b1;
		pkt_ch.pkt_length   <= len;
		pkt_ch.timestamp_us <= ts;
		do @(posedge clk); while (!pkt_ch.ready);
		gold.note_input(len, ts);
		cur_ts = ts;
	endtask

	task automatic write_tau(input logic [TAU_W-1:0] value);
		pkt_ch.valid <= 1'b0;
		while (gold.pending() != 0)
			@(posedge clk);
		cfg_ch.valid  <= 1'b1;
		cfg_ch.tau_us <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		gold.tau = value;
	endtask

	task automatic send_random(input int count);
		int unsigned      sel;
		logic [TS_W-1:0]  step;
		logic [LEN_W-1:0] len;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 60)
				step = $urandom_range(1, 1500);
			else if (sel < 70)
				step = $urandom_range(1, 8);
			else if (sel < 78)
				step = 0;
			else if (sel < 84)
				step = (TS_W'(1) << MAX_DELTA_BITS) + $urandom_range(0, 2) - 1;
			else if (sel < 92)
				step = $urandom;
			else
				step = $urandom - cur_ts;
			sel = $urandom_range(99);
			if (sel < 20)
				len = '0;
			else if (sel < 26)
				len = '1;
			else if (sel < 60)
				len = LEN_W'($urandom_range(40, 1500));
			else
				len = LEN_W'($urandom_range(0, 65535));
			send_pkt(len, cur_ts + step);
		end
	endtask

	initial begin
		arst_n              <= 1'b0;
		pkt_ch.valid        <= 1'b0;
		pkt_ch.pkt_length   <= '0;
		pkt_ch.timestamp_us <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.tau_us       <= '0;
		idle_pct = 26;
		cur_ts   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first item is measured from a zero time, so a zero stamp is a zero gap.
		send_pkt(16'd1500, 32'd0);
		send_pkt(16'hFFFF, 32'd1);
		send_pkt(16'd0, 32'd2);
		send_pkt(16'd1000, 32'd2 + (32'd1 << MAX_DELTA_BITS));
		send_pkt(16'd1000, cur_ts + (32'd1 << MAX_DELTA_BITS) + 32'd1);
		send_pkt(16'hFFFF, cur_ts + 32'hFFFF_FFFF);
		send_pkt(16'd40, 32'hFFFF_FFF0);
		send_pkt(16'd1, 32'h0000_0010);
		send_pkt(16'hFFFF, 32'h0000_0010);
		send_pkt(16'd0, 32'h0000_0010 + 32'd1000);
		send_pkt(16'hFFFF, cur_ts + 32'd1);
		send_pkt(16'd0, cur_ts + 32'd1);

		write_tau(24'd1);
		send_random(90);
		write_tau(24'hFF_FFFF);
		send_random(100);
		write_tau(24'd0);
		send_pkt(16'hFFFF, cur_ts + 32'd1);
		send_pkt(16'hFFFF, cur_ts + 32'd1);
		send_pkt(16'd0, cur_ts + 32'd1);
		send_random(80);
		write_tau(24'($urandom_range(1, 5000)));
		send_random(140);
		idle_pct = 0;
		write_tau(24'($urandom_range(1, 24'hFF_FFFF)));
		send_random(150);
		idle_pct = 26;
		write_tau(24'd50);
		send_random(120);
		write_tau(TAU_RESET);
		send_random(150);
		pkt_ch.valid <= 1'b0;

		while (gold.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d packets and ticks over eight time constants, tau zero included.",
			gold.n_items);
		$display("%0d results had a clamped gap and %0d estimates saturated.",
			gold.n_clamped, gold.n_saturated);
		if (gold.errors == 0 && gold.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
